// ===== src/point_store_edge_split_search_macros.svh =====
// Assertion macros for the point store with edge split and snap search.
`ifndef POINT_STORE_EDGE_SPLIT_SEARCH_MACROS_SVH
`define POINT_STORE_EDGE_SPLIT_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
// condition holds at every edge out of reset
`define PSESS_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("point store: check failed");
// consequence holds in the same cycle
`define PSESS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("point store: check failed");
// consequence holds in the next cycle
`define PSESS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("point store: check failed");
`else
`define PSESS_ASSERT(label, clk, rst_n, cond)
`define PSESS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PSESS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/psess_pkg.sv =====
// Types, codes and constants of the point store with edge split and snap search.
package psess_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int COORD_BITS_DEF = 32;

    localparam int LIMB_W = 32;
    localparam int OPND_W = 128;
    localparam int ACC_W  = 192;
    localparam int DD_W   = 66;
    localparam int SQ_W   = 33;
    localparam int TOL_W  = 99;
    localparam int DS_W   = 132;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_SPLIT = 2'd1;
    localparam logic [1:0] OP_SNAP  = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_NONE = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam logic [1:0] CFG_TOL    = 2'd0;
    localparam logic [1:0] CFG_SNAP   = 2'd1;
    localparam logic [1:0] CFG_MARGIN = 2'd2;

    localparam logic [15:0] TOL_RST    = 16'd66;
    localparam logic [31:0] SNAP_RST   = 32'd66;
    localparam logic [14:0] MARGIN_RST = 15'd33;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SP_INIT,
        ST_SN_INIT,
        ST_LOAD,
        ST_MUL,
        ST_DRAIN,
        ST_EVAL,
        ST_RESP
    } state_t;

    typedef enum logic [4:0] {
        U_DD0, U_DD1, U_DD2,
        U_CT, U_TOL, U_MM, U_LO, U_HM, U_HI,
        U_E0, U_E1, U_E2,
        U_V0, U_V1, U_V2,
        U_DOT0, U_DOT1, U_DOT2,
        U_DSQ, U_TV, U_TT, U_FR
    } uop_t;

    typedef struct packed {
        logic [OPND_W-1:0] x;
        logic [OPND_W-1:0] y;
        logic [2:0]        nx;
        logic [2:0]        ny;
        logic              neg;
        logic              clr;
    } mul_op_t;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        return v[32] ? 33'(-v) : 33'(v);
    endfunction

    function automatic logic [34:0] mag35(input logic signed [34:0] v);
        return v[34] ? 35'(-v) : 35'(v);
    endfunction

endpackage

// ===== src/point_store_edge_split_search.sv =====
// Point store with edge split search and snap search, one shared limb multiplier.
//
// Stores up to MAX_POINTS points (x, y, z in Q16.16) and answers one item at a time:
// opcode 0 appends a point (status 2 when full), opcode 1 searches the stored points in
// insertion order for the first one that splits edge AB and returns it with its Q0.16
// fraction, opcode 2 returns the first stored point within the snap radius of A. An add
// or an unused opcode has its result registered as it is accepted. All squared distances
// and products run through one 32 x 32 multiplier that walks the operands limb by limb
// into a 192-bit accumulator. A split query first squares the edge and its bounds, then
// gives each stored point a sphere test and, if it passes, a line and margin test, and
// finds the fraction of the point found bit by bit. A snap query tests each stored point
// in turn against the radius. The store needs no clearing pass; only points already
// written are ever read.
module point_store_edge_split_search #(
    parameter int MAX_POINTS = psess_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = psess_pkg::COORD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z, zero pad
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status, split_fraction, match_x, match_y, match_z, zero pad
    output logic [119:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int IN_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int SH      = 32 - IN_BITS;
    localparam int ACC_W   = psess_pkg::ACC_W;
    localparam int OPND_W  = psess_pkg::OPND_W;
    localparam int LIMB_W  = psess_pkg::LIMB_W;
    localparam int DD_W    = psess_pkg::DD_W;
    localparam int SQ_W    = psess_pkg::SQ_W;
    localparam int TOL_W   = psess_pkg::TOL_W;
    localparam int DS_W    = psess_pkg::DS_W;

    function automatic logic signed [31:0] narrow(input logic [31:0] w);
        logic signed [31:0] t;
        t = $signed(w) <<< SH;
        return t >>> SH;
    endfunction

    psess_pkg::state_t state_reg, state_next;
    psess_pkg::uop_t   uop_reg, uop_next;
    psess_pkg::mul_op_t mop;

    logic [15:0]  tol_cfg_reg;
    logic [31:0]  snap_cfg_reg;
    logic [14:0]  margin_cfg_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [1:0]       op_reg;
    logic             found_reg;

    logic signed [31:0] a_reg [3];
    logic signed [31:0] b_reg [3];
    logic signed [32:0] d_reg [3];
    logic signed [31:0] a_in [3];
    logic signed [31:0] b_in [3];

    logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];
    logic signed [COORD_BITS-1:0] mem_z [MAX_POINTS];
    logic signed [COORD_BITS-1:0] rd_x_reg, rd_y_reg, rd_z_reg;
    logic signed [31:0] p [3];

    logic signed [32:0] v [3];
    logic signed [34:0] e [3];
    logic [32:0] vm [3];
    logic [34:0] em [3];
    logic [32:0] dm [3];
    logic        vneg [3];

    logic [DD_W-1:0]  dd_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [TOL_W-1:0] tolsq_reg, lo_reg, hi_reg;
    logic [DD_W-1:0]  vv_reg, dot_reg;
    logic [DS_W-1:0]  ds_reg;
    logic [15:0]      f_reg;
    logic [3:0]       bit_reg;
    logic [15:0]      t_try;
    logic [16:0]      ct, hm;

    logic [ACC_W-1:0] acc_reg, acc_abs, acc_add, vs_w;
    logic [63:0]      prod_reg;
    logic [2:0]       off_reg;
    logic             pneg_reg, pv_reg;
    logic [1:0]       i_reg, j_reg;
    logic             mul_last;
    logic [LIMB_W-1:0] xl, yl;

    logic in_acc, out_free, store_full, last_point, mem_we;
    logic acc_zero, e_out, snap_hit, col_fail, lo_fail, hi_fail, frac_ok;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign out_free   = !m_axis_tvalid || m_axis_tready;
    assign store_full = (count_reg >= CNT_W'(MAX_POINTS));
    assign last_point = (CNT_W'(idx_reg + 1'b1) == count_reg);

    always_comb
    begin
        a_in[0] = narrow(s_axis_tdata[33:2]);
        a_in[1] = narrow(s_axis_tdata[65:34]);
        a_in[2] = narrow(s_axis_tdata[97:66]);
        b_in[0] = narrow(s_axis_tdata[129:98]);
        b_in[1] = narrow(s_axis_tdata[161:130]);
        b_in[2] = narrow(s_axis_tdata[193:162]);
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_cfg_reg    <= psess_pkg::TOL_RST;
            snap_cfg_reg   <= psess_pkg::SNAP_RST;
            margin_cfg_reg <= psess_pkg::MARGIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                psess_pkg::CFG_TOL:    tol_cfg_reg    <= cfg_data[15:0];
                psess_pkg::CFG_SNAP:   snap_cfg_reg   <= cfg_data;
                psess_pkg::CFG_MARGIN: margin_cfg_reg <= cfg_data[14:0];
                default:               ;
            endcase
        end
    end

    // point memory, one array per coordinate
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[count_reg[ADDR_W-1:0]] <= COORD_BITS'(a_in[0]);
            mem_y[count_reg[ADDR_W-1:0]] <= COORD_BITS'(a_in[1]);
            mem_z[count_reg[ADDR_W-1:0]] <= COORD_BITS'(a_in[2]);
        end
        rd_x_reg <= mem_x[idx_reg[ADDR_W-1:0]];
        rd_y_reg <= mem_y[idx_reg[ADDR_W-1:0]];
        rd_z_reg <= mem_z[idx_reg[ADDR_W-1:0]];
    end

    always_comb
    begin
        p[0] = 32'(rd_x_reg);
        p[1] = 32'(rd_y_reg);
        p[2] = 32'(rd_z_reg);
        for (int k = 0; k < 3; k++)
        begin
            v[k]    = 33'(p[k]) - 33'(a_reg[k]);
            e[k]    = (35'(p[k]) <<< 1) - 35'(a_reg[k]) - 35'(b_reg[k]);
            vm[k]   = psess_pkg::mag33(v[k]);
            em[k]   = psess_pkg::mag35(e[k]);
            dm[k]   = psess_pkg::mag33(d_reg[k]);
            vneg[k] = v[k][32] ^ d_reg[k][32];
        end
    end

    assign ct    = psess_pkg::ONE_Q16 - 17'(tol_cfg_reg);
    assign hm    = psess_pkg::ONE_Q16 - 17'(margin_cfg_reg);
    assign t_try = f_reg | (16'd1 << bit_reg);

    // operands of the shared multiplier for each micro-operation
    always_comb
    begin
        mop = '0;
        case (uop_reg)
            psess_pkg::U_DD0:  mop = '{OPND_W'(dm[0]), OPND_W'(dm[0]), 3'd2, 3'd2, 1'b0, 1'b1};
            psess_pkg::U_DD1:  mop = '{OPND_W'(dm[1]), OPND_W'(dm[1]), 3'd2, 3'd2, 1'b0, 1'b0};
            psess_pkg::U_DD2:  mop = '{OPND_W'(dm[2]), OPND_W'(dm[2]), 3'd2, 3'd2, 1'b0, 1'b0};
            psess_pkg::U_CT:   mop = '{OPND_W'(ct), OPND_W'(ct), 3'd1, 3'd1, 1'b0, 1'b1};
            psess_pkg::U_MM:   mop = '{OPND_W'(margin_cfg_reg), OPND_W'(margin_cfg_reg),
                                       3'd1, 3'd1, 1'b0, 1'b1};
            psess_pkg::U_HM:   mop = '{OPND_W'(hm), OPND_W'(hm), 3'd1, 3'd1, 1'b0, 1'b1};
            psess_pkg::U_TOL,
            psess_pkg::U_LO,
            psess_pkg::U_HI,
            psess_pkg::U_FR:   mop = '{OPND_W'(sq_reg), OPND_W'(dd_reg), 3'd2, 3'd3, 1'b0, 1'b1};
            psess_pkg::U_E0:   mop = '{OPND_W'(em[0]), OPND_W'(em[0]), 3'd2, 3'd2, 1'b0, 1'b1};
            psess_pkg::U_E1:   mop = '{OPND_W'(em[1]), OPND_W'(em[1]), 3'd2, 3'd2, 1'b0, 1'b0};
            psess_pkg::U_E2:   mop = '{OPND_W'(em[2]), OPND_W'(em[2]), 3'd2, 3'd2, 1'b0, 1'b0};
            psess_pkg::U_V0:   mop = '{OPND_W'(vm[0]), OPND_W'(vm[0]), 3'd2, 3'd2, 1'b0, 1'b1};
            psess_pkg::U_V1:   mop = '{OPND_W'(vm[1]), OPND_W'(vm[1]), 3'd2, 3'd2, 1'b0, 1'b0};
            psess_pkg::U_V2:   mop = '{OPND_W'(vm[2]), OPND_W'(vm[2]), 3'd2, 3'd2, 1'b0, 1'b0};
            psess_pkg::U_DOT0: mop = '{OPND_W'(vm[0]), OPND_W'(dm[0]), 3'd2, 3'd2, vneg[0], 1'b1};
            psess_pkg::U_DOT1: mop = '{OPND_W'(vm[1]), OPND_W'(dm[1]), 3'd2, 3'd2, vneg[1], 1'b0};
            psess_pkg::U_DOT2: mop = '{OPND_W'(vm[2]), OPND_W'(dm[2]), 3'd2, 3'd2, vneg[2], 1'b0};
            psess_pkg::U_DSQ:  mop = '{OPND_W'(dot_reg), OPND_W'(dot_reg), 3'd3, 3'd3, 1'b0, 1'b1};
            psess_pkg::U_TV:   mop = '{OPND_W'(tolsq_reg), OPND_W'(vv_reg), 3'd4, 3'd3, 1'b0, 1'b1};
            psess_pkg::U_TT:   mop = '{OPND_W'(t_try), OPND_W'(t_try), 3'd1, 3'd1, 1'b0, 1'b1};
            default:           mop = '0;
        endcase
    end

    assign xl       = mop.x[{i_reg, 5'b0} +: LIMB_W];
    assign yl       = mop.y[{j_reg, 5'b0} +: LIMB_W];
    assign mul_last = (i_reg == 2'(mop.nx - 3'd1)) && (j_reg == 2'(mop.ny - 3'd1));
    assign acc_add  = ACC_W'(prod_reg) << {off_reg, 5'b0};
    assign acc_abs  = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign vs_w     = ACC_W'({vv_reg, 32'b0});

    // tests on the finished product
    assign acc_zero = (acc_reg == '0);
    assign e_out    = (acc_reg > ACC_W'(dd_reg));
    assign snap_hit = (acc_reg <= ACC_W'({snap_cfg_reg, 16'b0}));
    assign col_fail = (ACC_W'({ds_reg, 32'b0}) < acc_reg);
    assign lo_fail  = (vs_w <= ACC_W'(lo_reg));
    assign hi_fail  = (vs_w >= ACC_W'(hi_reg));
    assign frac_ok  = (acc_reg <= vs_w);

    // limb counters, partial product register, accumulator
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg  <= '0;
            j_reg  <= '0;
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= (state_reg == psess_pkg::ST_MUL);
            if (state_reg == psess_pkg::ST_MUL)
            begin
                if (j_reg == 2'(mop.ny - 3'd1))
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 2'd1;
                end
                else
                begin
                    j_reg <= j_reg + 2'd1;
                end
            end
            else
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(xl) * 64'(yl);
        off_reg  <= 3'(i_reg) + 3'(j_reg);
        pneg_reg <= mop.neg;
        if (state_reg == psess_pkg::ST_MUL && i_reg == '0 && j_reg == '0 && mop.clr)
            acc_reg <= '0;
        else if (pv_reg)
            acc_reg <= pneg_reg ? acc_reg - acc_add : acc_reg + acc_add;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        uop_next   = uop_reg;
        case (state_reg)
            psess_pkg::ST_IDLE:
            begin
                if (in_acc && s_axis_tdata[1:0] == psess_pkg::OP_SPLIT)
                    state_next = psess_pkg::ST_SP_INIT;
                else if (in_acc && s_axis_tdata[1:0] == psess_pkg::OP_SNAP)
                    state_next = psess_pkg::ST_SN_INIT;
            end
            psess_pkg::ST_SP_INIT:
            begin
                state_next = psess_pkg::ST_MUL;
                uop_next   = psess_pkg::U_DD0;
            end
            psess_pkg::ST_SN_INIT:
                state_next = (count_reg == '0) ? psess_pkg::ST_RESP : psess_pkg::ST_LOAD;
            psess_pkg::ST_LOAD:
            begin
                state_next = psess_pkg::ST_MUL;
                uop_next   = (op_reg == psess_pkg::OP_SPLIT) ? psess_pkg::U_E0 : psess_pkg::U_V0;
            end
            psess_pkg::ST_MUL:
                if (mul_last)
                    state_next = psess_pkg::ST_DRAIN;
            psess_pkg::ST_DRAIN:
                state_next = psess_pkg::ST_EVAL;
            psess_pkg::ST_EVAL:
            begin
                state_next = psess_pkg::ST_MUL;
                case (uop_reg)
                    psess_pkg::U_DD0:  uop_next = psess_pkg::U_DD1;
                    psess_pkg::U_DD1:  uop_next = psess_pkg::U_DD2;
                    psess_pkg::U_DD2:
                        if (acc_zero)
                            state_next = psess_pkg::ST_RESP;
                        else
                            uop_next = psess_pkg::U_CT;
                    psess_pkg::U_CT:   uop_next = psess_pkg::U_TOL;
                    psess_pkg::U_TOL:  uop_next = psess_pkg::U_MM;
                    psess_pkg::U_MM:   uop_next = psess_pkg::U_LO;
                    psess_pkg::U_LO:   uop_next = psess_pkg::U_HM;
                    psess_pkg::U_HM:   uop_next = psess_pkg::U_HI;
                    psess_pkg::U_HI:
                        state_next = (count_reg == '0) ? psess_pkg::ST_RESP
                                                       : psess_pkg::ST_LOAD;
                    psess_pkg::U_E0:   uop_next = psess_pkg::U_E1;
                    psess_pkg::U_E1:   uop_next = psess_pkg::U_E2;
                    psess_pkg::U_E2:
                        if (e_out)
                            state_next = last_point ? psess_pkg::ST_RESP : psess_pkg::ST_LOAD;
                        else
                            uop_next = psess_pkg::U_V0;
                    psess_pkg::U_V0:   uop_next = psess_pkg::U_V1;
                    psess_pkg::U_V1:   uop_next = psess_pkg::U_V2;
                    psess_pkg::U_V2:
                        if (op_reg == psess_pkg::OP_SPLIT && !acc_zero)
                            uop_next = psess_pkg::U_DOT0;
                        else if (op_reg == psess_pkg::OP_SNAP && snap_hit)
                            state_next = psess_pkg::ST_RESP;
                        else
                            state_next = last_point ? psess_pkg::ST_RESP : psess_pkg::ST_LOAD;
                    psess_pkg::U_DOT0: uop_next = psess_pkg::U_DOT1;
                    psess_pkg::U_DOT1: uop_next = psess_pkg::U_DOT2;
                    psess_pkg::U_DOT2: uop_next = psess_pkg::U_DSQ;
                    psess_pkg::U_DSQ:  uop_next = psess_pkg::U_TV;
                    psess_pkg::U_TV:
                        if (col_fail || lo_fail || hi_fail)
                            state_next = last_point ? psess_pkg::ST_RESP : psess_pkg::ST_LOAD;
                        else
                            uop_next = psess_pkg::U_TT;
                    psess_pkg::U_TT:   uop_next = psess_pkg::U_FR;
                    psess_pkg::U_FR:
                        if (bit_reg == '0)
                            state_next = psess_pkg::ST_RESP;
                        else
                            uop_next = psess_pkg::U_TT;
                    default:           state_next = psess_pkg::ST_RESP;
                endcase
            end
            psess_pkg::ST_RESP:
                if (out_free)
                    state_next = psess_pkg::ST_IDLE;
            default:
                state_next = psess_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = (state_reg == psess_pkg::ST_IDLE) && out_free;
        mem_we        = in_acc && s_axis_tdata[1:0] == psess_pkg::OP_ADD && !store_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psess_pkg::ST_IDLE;
            uop_reg   <= psess_pkg::U_DD0;
            count_reg <= '0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
            op_reg    <= psess_pkg::OP_ADD;
        end
        else
        begin
            state_reg <= state_next;
            uop_reg   <= uop_next;
            if (mem_we)
                count_reg <= count_reg + 1'b1;
            if (in_acc)
                op_reg <= s_axis_tdata[1:0];
            if (state_reg == psess_pkg::ST_SP_INIT || state_reg == psess_pkg::ST_SN_INIT)
            begin
                found_reg <= 1'b0;
                idx_reg   <= '0;
            end
            if (state_reg == psess_pkg::ST_EVAL)
            begin
                if (state_next == psess_pkg::ST_LOAD && uop_reg != psess_pkg::U_HI)
                    idx_reg <= idx_reg + 1'b1;
                if (uop_reg == psess_pkg::U_V2 && op_reg == psess_pkg::OP_SNAP && snap_hit)
                    found_reg <= 1'b1;
                if (uop_reg == psess_pkg::U_FR && bit_reg == '0)
                    found_reg <= 1'b1;
            end
        end
    end

    // query operands and intermediate products
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int k = 0; k < 3; k++)
            begin
                a_reg[k] <= a_in[k];
                b_reg[k] <= b_in[k];
            end
        end
        if (state_reg == psess_pkg::ST_SP_INIT)
        begin
            for (int k = 0; k < 3; k++)
                d_reg[k] <= 33'(b_reg[k]) - 33'(a_reg[k]);
        end
        if (state_reg == psess_pkg::ST_EVAL)
        begin
            case (uop_reg)
                psess_pkg::U_DD2:  dd_reg    <= acc_reg[DD_W-1:0];
                psess_pkg::U_CT,
                psess_pkg::U_MM,
                psess_pkg::U_HM,
                psess_pkg::U_TT:   sq_reg    <= acc_reg[SQ_W-1:0];
                psess_pkg::U_TOL:  tolsq_reg <= acc_reg[TOL_W-1:0];
                psess_pkg::U_LO:   lo_reg    <= acc_reg[TOL_W-1:0];
                psess_pkg::U_HI:   hi_reg    <= acc_reg[TOL_W-1:0];
                psess_pkg::U_V2:   vv_reg    <= acc_reg[DD_W-1:0];
                psess_pkg::U_DOT2: dot_reg   <= acc_abs[DD_W-1:0];
                psess_pkg::U_DSQ:  ds_reg    <= acc_reg[DS_W-1:0];
                psess_pkg::U_TV:
                begin
                    f_reg   <= '0;
                    bit_reg <= 4'd15;
                end
                psess_pkg::U_FR:
                begin
                    if (frac_ok)
                        f_reg <= t_try;
                    if (bit_reg != '0)
                        bit_reg <= bit_reg - 4'd1;
                end
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if ((in_acc && s_axis_tdata[1:0] != psess_pkg::OP_SPLIT
                  && s_axis_tdata[1:0] != psess_pkg::OP_SNAP)
                 || (state_reg == psess_pkg::ST_RESP && out_free))
            m_axis_tvalid <= 1'b1;
        else if (m_axis_tready)
            m_axis_tvalid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && s_axis_tdata[1:0] != psess_pkg::OP_SPLIT
            && s_axis_tdata[1:0] != psess_pkg::OP_SNAP)
        begin
            if (s_axis_tdata[1:0] == psess_pkg::OP_ADD)
                m_axis_tdata <= {118'd0,
                                 store_full ? psess_pkg::STAT_FULL : psess_pkg::STAT_OK};
            else
                m_axis_tdata <= {118'd0, psess_pkg::STAT_NONE};
        end
        else if (state_reg == psess_pkg::ST_RESP && out_free)
        begin
            if (found_reg)
                m_axis_tdata <= {6'd0, p[2], p[1], p[0],
                                 (op_reg == psess_pkg::OP_SPLIT) ? f_reg : 16'd0,
                                 psess_pkg::STAT_OK};
            else
                m_axis_tdata <= {118'd0, psess_pkg::STAT_NONE};
        end
    end

`include "point_store_edge_split_search_macros.svh"

    `PSESS_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_POINTS))
    `PSESS_ASSERT_NEXT(a_add_counts, clk, rst_n, mem_we, count_reg == $past(count_reg) + 1'b1)
    `PSESS_ASSERT_IMP(a_no_overrun, clk, rst_n, in_acc, !m_axis_tvalid || m_axis_tready)
    `PSESS_ASSERT_IMP(a_idx_in_store, clk, rst_n, state_reg == psess_pkg::ST_LOAD, idx_reg < count_reg)

endmodule

// ===== verif/point_store_edge_split_search_tb.sv =====
// Self-checking testbench for the point store with edge split and snap search.
`timescale 1ns / 1ps

module point_store_edge_split_search_tb;

    localparam int      STORE_DEPTH = 4096;
    localparam longint  CYCLE_LIMIT = 5000000;
    localparam int      RAND_ITEMS  = 120;

    typedef logic [255:0] wide_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] az;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bz;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] frac;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] mz;
    } res_t;

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t r;
    } row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // opcode, point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z, zero pad
    logic [199:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // status, split_fraction, match_x, match_y, match_z, zero pad
    logic [119:0] m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = psess_pkg::CFG_TOL;
    logic [31:0]  cfg_data = '0;

    point_store_edge_split_search DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // shadow of the block's store and registers
    logic signed [31:0] pts_x [STORE_DEPTH];
    logic signed [31:0] pts_y [STORE_DEPTH];
    logic signed [31:0] pts_z [STORE_DEPTH];
    int          pts_count = 0;
    logic [15:0] tol_reg = psess_pkg::TOL_RST;
    logic [31:0] snap_reg = psess_pkg::SNAP_RST;
    logic [14:0] margin_reg = psess_pkg::MARGIN_RST;

    res_t pending_results [$];
    int   errors = 0;
    int   send_idle = 0;
    int   recv_stall = 0;
    longint cycles = 0;

    function automatic wide_t magw(longint v);
        return v < 0 ? wide_t'(-v) : wide_t'(v);
    endfunction

    function automatic wide_t sq_len(longint x, longint y, longint z);
        return magw(x) * magw(x) + magw(y) * magw(y) + magw(z) * magw(z);
    endfunction

    // first stored point splitting edge AB, -1 if none
    function automatic int find_split(cmd_t c, output logic [15:0] frac);
        longint a[3], b[3], d[3], p[3], v[3], e[3];
        wide_t dd, tolsq, losq, hisq, vv, pos, neg, dot, pr, vs;
        longint ct, m;
        logic [16:0] f, t;
        a[0] = longint'($signed(c.ax)); a[1] = longint'($signed(c.ay));
        a[2] = longint'($signed(c.az));
        b[0] = longint'($signed(c.bx)); b[1] = longint'($signed(c.by));
        b[2] = longint'($signed(c.bz));
        frac = '0;
        for (int k = 0; k < 3; k++)
            d[k] = b[k] - a[k];
        dd = sq_len(d[0], d[1], d[2]);
        if (dd == 0)
            return -1;
        ct = 65536 - longint'(tol_reg);
        m = longint'(margin_reg);
        tolsq = wide_t'(ct) * wide_t'(ct) * dd;
        losq = wide_t'(m) * wide_t'(m) * dd;
        hisq = wide_t'(65536 - m) * wide_t'(65536 - m) * dd;
        for (int i = 0; i < pts_count; i++) begin
            p[0] = pts_x[i]; p[1] = pts_y[i]; p[2] = pts_z[i];
            for (int k = 0; k < 3; k++) begin
                v[k] = p[k] - a[k];
                e[k] = 2 * p[k] - a[k] - b[k];
            end
            if (sq_len(e[0], e[1], e[2]) > dd)
                continue;
            vv = sq_len(v[0], v[1], v[2]);
            if (vv == 0)
                continue;
            pos = '0;
            neg = '0;
            for (int k = 0; k < 3; k++) begin
                pr = magw(v[k]) * magw(d[k]);
                if ((v[k] < 0) != (d[k] < 0))
                    neg = neg + pr;
                else
                    pos = pos + pr;
            end
            dot = pos >= neg ? pos - neg : neg - pos;
            if ((dot * dot) << 32 < tolsq * vv)
                continue;
            vs = vv << 32;
            if (vs <= losq || vs >= hisq)
                continue;
            f = '0;
            for (int bitpos = 15; bitpos >= 0; bitpos--) begin
                t = f | (17'd1 << bitpos);
                if (wide_t'(t) * wide_t'(t) * dd <= vs)
                    f = t;
            end
            frac = f[15:0];
            return i;
        end
        return -1;
    endfunction

    function automatic int find_snap(cmd_t c);
        wide_t lim;
        lim = wide_t'(snap_reg) << 16;
        for (int i = 0; i < pts_count; i++) begin
            if (sq_len(longint'($signed(c.ax)) - pts_x[i],
                       longint'($signed(c.ay)) - pts_y[i],
                       longint'($signed(c.az)) - pts_z[i]) <= lim)
                return i;
        end
        return -1;
    endfunction

    // work out the answer to one item and advance the shadow store
    function automatic res_t apply_command(cmd_t c);
        res_t r;
        int hit;
        logic [15:0] f;
        r = '0;
        r.status = psess_pkg::STAT_NONE;
        hit = -1;
        f = '0;
        case (c.op)
            psess_pkg::OP_ADD:
                if (pts_count >= STORE_DEPTH)
                    r.status = psess_pkg::STAT_FULL;
                else begin
                    pts_x[pts_count] = c.ax;
                    pts_y[pts_count] = c.ay;
                    pts_z[pts_count] = c.az;
                    pts_count++;
                    r.status = psess_pkg::STAT_OK;
                end
            psess_pkg::OP_SPLIT: hit = find_split(c, f);
            psess_pkg::OP_SNAP:  hit = find_snap(c);
            default: ;
        endcase
        if (hit >= 0) begin
            r.status = psess_pkg::STAT_OK;
            r.frac = (c.op == psess_pkg::OP_SPLIT) ? f : 16'd0;
            r.mx = pts_x[hit];
            r.my = pts_y[hit];
            r.mz = pts_z[hit];
        end
        return r;
    endfunction

    // append one awaited result item
    task automatic queue_result(res_t r);
        pending_results = {pending_results, r};
    endtask

    task automatic send_cmd(cmd_t c, bit typed = 1'b0, res_t typed_res = '0);
        res_t r;
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {6'd0, c.bz, c.by, c.bx, c.az, c.ay, c.ax, c.op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        r = apply_command(c);
        queue_result(typed ? typed_res : r);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // write all three registers back to back, then drop the enable
    task automatic set_regs(logic [15:0] tol, logic [31:0] snap, logic [14:0] margin);
        cfg_we <= 1'b1;
        cfg_index <= psess_pkg::CFG_TOL;
        cfg_data <= {16'd0, tol};
        @(posedge clk);
        cfg_index <= psess_pkg::CFG_SNAP;
        cfg_data <= snap;
        @(posedge clk);
        cfg_index <= psess_pkg::CFG_MARGIN;
        cfg_data <= {17'd0, margin};
        @(posedge clk);
        cfg_we <= 1'b0;
        tol_reg = tol;
        snap_reg = snap;
        margin_reg = margin;
    endtask

    function automatic cmd_t make_cmd(logic [1:0] op, logic [31:0] ax, logic [31:0] ay,
                                      logic [31:0] az, logic [31:0] bx = 0,
                                      logic [31:0] by = 0, logic [31:0] bz = 0);
        cmd_t c;
        c = '{op, ax, ay, az, bx, by, bz};
        return c;
    endfunction

    function automatic longint srand(int lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk) begin
        res_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.frac   = m_axis_tdata[17:2];
            got.mx     = m_axis_tdata[49:18];
            got.my     = m_axis_tdata[81:50];
            got.mz     = m_axis_tdata[113:82];
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item %h", got);
            end
            else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.frac !== want.frac ||
                    got.mx !== want.mx || got.my !== want.my || got.mz !== want.mz) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp st=%0d fr=%h m=%h/%h/%h",
                                  " got st=%0d fr=%h m=%h/%h/%h"},
                                 want.status, want.frac, want.mx, want.my, want.mz,
                                 got.status, got.frac, got.mx, got.my, got.mz);
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        row_t   tbl [17];
        cmd_t   c;
        longint a[3], d[3], bb[3], p[3];
        int     steps, j, n, sel, idx;

        tbl[0]  = '{make_cmd(psess_pkg::OP_SPLIT, 0, 0, 0, 32'h20000), 1,
                    '{psess_pkg::STAT_NONE, 0, 0, 0, 0}};
        tbl[1]  = '{make_cmd(psess_pkg::OP_SNAP, 0, 0, 0), 1,
                    '{psess_pkg::STAT_NONE, 0, 0, 0, 0}};
        tbl[2]  = '{make_cmd(2'd3, 1, 2, 3, 4, 5, 6), 1, '{psess_pkg::STAT_NONE, 0, 0, 0, 0}};
        tbl[3]  = '{make_cmd(psess_pkg::OP_ADD, 0, 0, 0), 1, '{psess_pkg::STAT_OK, 0, 0, 0, 0}};
        tbl[4]  = '{make_cmd(psess_pkg::OP_ADD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF),
                    1, '{psess_pkg::STAT_OK, 0, 0, 0, 0}};
        tbl[5]  = '{make_cmd(psess_pkg::OP_ADD, 32'h80000000, 32'h80000000, 32'h80000000),
                    1, '{psess_pkg::STAT_OK, 0, 0, 0, 0}};
        tbl[6]  = '{make_cmd(psess_pkg::OP_ADD, 32'h10000, 0, 0), 1,
                    '{psess_pkg::STAT_OK, 0, 0, 0, 0}};
        // midpoint of the edge, point at A is skipped
        tbl[7]  = '{make_cmd(psess_pkg::OP_SPLIT, 0, 0, 0, 32'h20000), 1,
                    '{psess_pkg::STAT_OK, 16'h8000, 32'h10000, 0, 0}};
        // zero-length edge
        tbl[8]  = '{make_cmd(psess_pkg::OP_SPLIT, 5, 5, 5, 5, 5, 5), 1,
                    '{psess_pkg::STAT_NONE, 0, 0, 0, 0}};
        tbl[9]  = '{make_cmd(psess_pkg::OP_SPLIT, 32'h10000, 0, 0, 32'h30000), 1,
                    '{psess_pkg::STAT_NONE, 0, 0, 0, 0}};
        tbl[10] = '{make_cmd(psess_pkg::OP_SNAP, 0, 0, 0), 1, '{psess_pkg::STAT_OK, 0, 0, 0, 0}};
        tbl[11] = '{make_cmd(psess_pkg::OP_SNAP, 3, 0, 0), 0, '0};
        tbl[12] = '{make_cmd(psess_pkg::OP_SNAP, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 1,
                    '{psess_pkg::STAT_OK, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF}};
        tbl[13] = '{make_cmd(psess_pkg::OP_SPLIT, 32'h80000000, 32'h80000000, 32'h80000000,
                             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF), 0, '0};
        tbl[14] = '{make_cmd(psess_pkg::OP_SPLIT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h80000000, 32'h80000000, 32'h80000000), 0, '0};
        tbl[15] = '{make_cmd(2'd3, '1, '1, '1, '1, '1, '1), 1,
                    '{psess_pkg::STAT_NONE, 0, 0, 0, 0}};
        tbl[16] = '{make_cmd(psess_pkg::OP_SNAP, 32'h400000, 32'h400000, 0), 0, '0};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle = 27;
        recv_stall = 49;
        foreach (tbl[i])
            send_cmd(tbl[i].c, tbl[i].typed, tbl[i].r);
        drain_results();

        n = 0;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin set_regs(16'hFFFF, 32'd0, 15'd0);
                   send_idle = 27; recv_stall = 49; end
                1: begin set_regs(16'd0, 32'hFFFFFFFF, 15'h7FFF);
                   send_idle = 49; recv_stall = 27; end
                default: begin set_regs(16'd1000, 32'd5000, 15'd2000);
                   send_idle = 0; recv_stall = 0; end
            endcase
            while (n < RAND_ITEMS * (phase + 1) / 3) begin
                sel = $urandom_range(99);
                if (sel < 45) begin
                    // point on a known edge, then the split query for that edge
                    steps = $urandom_range(2, 16);
                    j = $urandom_range(1, steps - 1);
                    for (int k = 0; k < 3; k++) begin
                        a[k] = srand(1 << 22);
                        d[k] = srand(4095);
                        bb[k] = a[k] + d[k] * steps;
                        p[k] = a[k] + d[k] * j + ($urandom_range(3) == 0 ? srand(3) : 0);
                    end
                    send_cmd(make_cmd(psess_pkg::OP_ADD, 32'(p[0]), 32'(p[1]), 32'(p[2])));
                    if ($urandom_range(1))
                        send_cmd(make_cmd(psess_pkg::OP_SPLIT, 32'(a[0]), 32'(a[1]), 32'(a[2]),
                                          32'(bb[0]), 32'(bb[1]), 32'(bb[2])));
                    else
                        send_cmd(make_cmd(psess_pkg::OP_SPLIT, 32'(bb[0]), 32'(bb[1]),
                                          32'(bb[2]), 32'(a[0]), 32'(a[1]), 32'(a[2])));
                    n += 2;
                end
                else if (sel < 75 && pts_count > 0) begin
                    // query close to a stored point
                    idx = $urandom_range(pts_count - 1);
                    send_cmd(make_cmd(psess_pkg::OP_SNAP,
                                      32'(longint'(pts_x[idx]) +
                                          srand(1 << ($urandom_range(12)))),
                                      32'(longint'(pts_y[idx]) + srand(15)),
                                      32'(longint'(pts_z[idx]) + srand(15))));
                    n++;
                end
                else begin
                    c = make_cmd(2'($urandom_range(3)), $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                    send_cmd(c);
                    n++;
                end
            end
            // hold off until every result is back before touching the registers
            drain_results();
        end

        // a last snap on the oldest point and a short edge across the store
        send_cmd(make_cmd(psess_pkg::OP_SNAP, pts_x[0], pts_y[0], pts_z[0]));
        send_cmd(make_cmd(psess_pkg::OP_SPLIT, 32'h1000, 0, 0, 32'h1001, 0, 0));
        drain_results();
        repeat (50) @(posedge clk);

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
